// ===== rtl/sqv_pkg.sv =====
// ----------------------------------------------------------------------------
// sqv_pkg
// Shared types, codes and constants of the sprite quad vertex generator.
// ----------------------------------------------------------------------------
package sqv_pkg;

  localparam int VERTEX_COUNT_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF        = 16;
  localparam int CORDIC_STEPS          = 24;
  localparam int COUNT_W               = 32;
  localparam int DIV_W                 = 48;
  localparam int IN_DATA_W             = 264;
  localparam int OUT_DATA_W            = 176;
  localparam logic signed [33:0] Q30_INV_GAIN = 34'sd652032874;

  localparam logic [1:0] FUNC_BEGIN = 2'd0;
  localparam logic [1:0] FUNC_DRAW  = 2'd1;
  localparam logic [1:0] FUNC_END   = 2'd2;

  typedef struct packed {
    logic        err;
    logic        flush;
    logic        bottom_up;
    logic [COUNT_W-1:0] count;
    logic [31:0] texture_size;
    logic [63:0] source_rect;
    logic [63:0] dest_rect;
    logic [31:0] tint;
    logic [15:0] angle;
    logic [31:0] pivot;
    logic [1:0]  flip;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/sprite_quad_vertex_generator_top.sv =====
// ----------------------------------------------------------------------------
// sprite_quad_vertex_generator_top
// Turns each sprite draw beat into four corner vertex beats, or one error beat.
//
//   Channel   Dir  tdata / tuser                              tlast
//   s_*       in   264-bit sprite fields / func               -
//   m_*       out  176-bit vertex fields / flush, error flags last vertex or error
//
// Begin and end beats are taken and produce nothing.
// In the back a sprite runs eight 48-step serial divisions and a
// 24-step CORDIC; an early draw yields only one error beat.
// A two-entry queue lets the front take beats while the back works or
// the output stalls. Reset is synchronous and clears all batch state.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_generator_top #(
  parameter int VERTEX_COUNT_BITS = sqv_pkg::VERTEX_COUNT_BITS_DEF,
  parameter int ANGLE_BITS        = sqv_pkg::ANGLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // texture_id, texture_size, bottom_up, source_rect, dest_rect, tint,
  // angle, pivot, flip, zero pad
  input  logic [sqv_pkg::IN_DATA_W-1:0]  s_tdata,
  // func
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // pos_x, pos_y, tex_u, tex_v, vertex_color, vertex_number
  output logic [sqv_pkg::OUT_DATA_W-1:0] m_tdata,
  // flush_before, draw_error
  output logic [1:0]                     m_tuser,
  output logic                           m_tlast
);

  sqv_pkg::job_t        wr_job;
  sqv_pkg::job_t        rd_job;
  sqv_pkg::queue_stat_t stat;
  logic                 push;
  logic                 pop;

  sqv_front #(
    .VERTEX_COUNT_BITS(VERTEX_COUNT_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .stat(stat),
    .push(push),
    .job(wr_job)
  );

  sqv_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wr_job(wr_job),
    .pop(pop),
    .rd_job(rd_job),
    .stat(stat)
  );

  sqv_back #(
    .VERTEX_COUNT_BITS(VERTEX_COUNT_BITS),
    .ANGLE_BITS(ANGLE_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .rd_job(rd_job),
    .stat(stat),
    .pop(pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

endmodule

// ===== rtl/sqv_queue.sv =====
// ----------------------------------------------------------------------------
// sqv_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module sqv_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sqv_pkg::job_t      wr_job,
  input  logic               pop,
  output sqv_pkg::job_t      rd_job,
  output sqv_pkg::queue_stat_t stat
);

  sqv_pkg::job_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign rd_job     = entry[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !stat.full)
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !stat.empty)
    else $error("job popped from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");

endmodule

// ===== rtl/sqv_front.sv =====
// ----------------------------------------------------------------------------
// sqv_front
// Accepts input beats, keeps the batch state and queues draw jobs.
// ----------------------------------------------------------------------------
module sqv_front #(
  parameter int VERTEX_COUNT_BITS = sqv_pkg::VERTEX_COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sqv_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [1:0]                    s_tuser,
  input  sqv_pkg::queue_stat_t          stat,
  output logic                          push,
  output sqv_pkg::job_t                 job
);

  logic                         batch_open;
  logic [VERTEX_COUNT_BITS-1:0] vertex_count;
  logic [15:0]                  bound_texture;
  logic                         texture_bound;
  logic                         bound_bottom_up;

  logic        accept;
  logic [15:0] tex_id;
  logic        new_tex;
  logic        flush;
  logic        bu_now;
  logic [VERTEX_COUNT_BITS-1:0] base;

  assign s_tready = !stat.full;
  assign accept   = s_tvalid && s_tready;
  assign tex_id   = s_tdata[15:0];
  assign new_tex  = !texture_bound || (bound_texture != tex_id);
  assign flush    = new_tex && texture_bound;
  assign bu_now   = new_tex ? s_tdata[48] : bound_bottom_up;
  assign base     = flush ? '0 : vertex_count;
  assign push     = accept && (s_tuser == sqv_pkg::FUNC_DRAW);

  always_comb begin
    job.err          = !batch_open;
    job.flush        = batch_open && flush;
    job.bottom_up    = bu_now;
    job.count        = sqv_pkg::COUNT_W'(base);
    job.texture_size = s_tdata[47:16];
    job.source_rect  = s_tdata[112:49];
    job.dest_rect    = s_tdata[176:113];
    job.tint         = s_tdata[208:177];
    job.angle        = s_tdata[224:209];
    job.pivot        = s_tdata[256:225];
    job.flip         = s_tdata[258:257];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_open      <= 1'b0;
      vertex_count    <= '0;
      bound_texture   <= 16'd0;
      texture_bound   <= 1'b0;
      bound_bottom_up <= 1'b0;
    end else if (accept) begin
      if (s_tuser == sqv_pkg::FUNC_BEGIN) begin
        batch_open <= 1'b1;
      end else if (s_tuser == sqv_pkg::FUNC_END) begin
        vertex_count  <= '0;
        texture_bound <= 1'b0;
        batch_open    <= 1'b0;
      end else if (s_tuser == sqv_pkg::FUNC_DRAW && batch_open) begin
        if (new_tex) begin
          texture_bound   <= 1'b1;
          bound_texture   <= tex_id;
          bound_bottom_up <= s_tdata[48];
        end
        vertex_count <= base + VERTEX_COUNT_BITS'(4);
      end
    end
  end

endmodule

// ===== rtl/sqv_back.sv =====
// ----------------------------------------------------------------------------
// sqv_back
// Works one sprite job: eight serial divisions, a CORDIC, the rotation
// products and four corner vertices into the output register, or an error beat.
// ----------------------------------------------------------------------------
module sqv_back #(
  parameter int VERTEX_COUNT_BITS = sqv_pkg::VERTEX_COUNT_BITS_DEF,
  parameter int ANGLE_BITS        = sqv_pkg::ANGLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sqv_pkg::job_t                  rd_job,
  input  sqv_pkg::queue_stat_t           stat,
  output logic                           pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sqv_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]                     m_tuser,
  output logic                           m_tlast
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NUM  = 4'd1;
  localparam logic [3:0] S_DVS  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_SAT  = 4'd4;
  localparam logic [3:0] S_CORD = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_ROT  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;
  localparam logic [3:0] S_ERR  = 4'd9;

  localparam int DW = sqv_pkg::DIV_W;
  localparam logic [31:0] PH_MASK = ~((32'(1) << (32 - ANGLE_BITS)) - 32'(1));

  logic [3:0] state;
  sqv_pkg::job_t job_r;
  logic [2:0] d;
  logic [5:0] bitc;
  logic signed [DW:0] num_s;
  logic signed [16:0] den_s;
  logic [DW-1:0] num_mag;
  logic [15:0]   den_mag;
  logic [16:0]   rem;
  logic          q_neg;
  logic signed [31:0] res [8];
  logic signed [33:0] cx, cy, cz;
  logic          cneg;
  logic [4:0]    it;
  logic signed [63:0] prod [8];
  logic [2:0]    p;
  logic [1:0]    k;
  logic signed [33:0] rx, ry;

  logic signed [15:0] sx, sy, sw, sh, dxs, dys, dws, dhs, ox, oy;
  logic signed [20:0] term;
  logic signed [15:0] mulv;
  logic signed [36:0] mprod;
  logic signed [16:0] den_c;
  logic [16:0] rs;
  logic        ge;
  logic signed [33:0] sh_x, sh_y;
  logic [31:0] phase;
  logic signed [31:0] cs, sn, ma, mb;
  logic        xi, yi;
  logic signed [63:0] sum_x, sum_y;
  logic        slot_free;
  logic        load;
  logic signed [31:0] u_sel, v_sel;
  logic [31:0] pos_x, pos_y, tex_v;
  logic [VERTEX_COUNT_BITS-1:0] vn;

  assign sx  = job_r.source_rect[15:0];
  assign sy  = job_r.source_rect[31:16];
  assign sw  = job_r.source_rect[47:32];
  assign sh  = job_r.source_rect[63:48];
  assign dxs = job_r.dest_rect[15:0];
  assign dys = job_r.dest_rect[31:16];
  assign dws = job_r.dest_rect[47:32];
  assign dhs = job_r.dest_rect[63:48];
  assign ox  = job_r.pivot[15:0];
  assign oy  = job_r.pivot[31:16];

  always_comb begin
    unique case (d)
      3'd0: term = 21'(sx);
      3'd1: term = 21'(sx) + 21'(sw);
      3'd2: term = 21'(sy);
      3'd3: term = 21'(sy) + 21'(sh);
      3'd4: term = -21'(ox);
      3'd5: term = (21'(sw) <<< 4) - 21'(ox);
      3'd6: term = -21'(oy);
      default: term = (21'(sh) <<< 4) - 21'(oy);
    endcase
    unique case (d[2:1])
      2'd0: den_c = {1'b0, job_r.texture_size[15:0]};
      2'd1: den_c = {1'b0, job_r.texture_size[31:16]};
      2'd2: den_c = 17'(sw);
      default: den_c = 17'(sh);
    endcase
  end

  assign mulv  = d[1] ? dhs : dws;
  assign mprod = term * mulv;

  assign rs = {rem[15:0], num_mag[DW-1]};
  assign ge = (rs >= {1'b0, den_mag});

  assign sh_x = cy >>> it;
  assign sh_y = cx >>> it;
  assign phase = {job_r.angle, 16'h0000} & PH_MASK;

  assign cs = 32'(cneg ? -cx : cx);
  assign sn = 32'(cneg ? -cy : cy);
  assign ma = p[2] ? (p[0] ? res[7] : res[6]) : (p[0] ? res[5] : res[4]);
  assign mb = p[1] ? sn : cs;

  assign xi = (k == 2'd1) || (k == 2'd2);
  assign yi = k[1];
  assign sum_x = (xi ? prod[1] : prod[0]) - (yi ? prod[7] : prod[6]) + 64'sd536870912;
  assign sum_y = (xi ? prod[3] : prod[2]) + (yi ? prod[5] : prod[4]) + 64'sd536870912;

  assign slot_free = !m_tvalid || m_tready;
  assign load      = ((state == S_OUT) || (state == S_ERR)) && slot_free;
  assign u_sel = (xi ^ job_r.flip[0]) ? res[1] : res[0];
  assign v_sel = (yi ^ job_r.flip[1]) ? res[3] : res[2];
  assign pos_x = sqv_pkg::sat32((35'(dxs) <<< 16) + 35'(rx));
  assign pos_y = sqv_pkg::sat32((35'(dys) <<< 16) + 35'(ry));
  assign tex_v = job_r.bottom_up ? sqv_pkg::sat32(35'sd65536 - 35'(v_sel)) : v_sel;
  assign vn    = VERTEX_COUNT_BITS'(job_r.count) + VERTEX_COUNT_BITS'(k);

  assign pop = (state == S_IDLE) && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!stat.empty) begin
            job_r <= rd_job;
            d     <= 3'd0;
            state <= rd_job.err ? S_ERR : S_NUM;
          end
        end
        S_NUM: begin
          num_s <= d[2] ? ((DW+1)'(mprod) <<< 12) : ((DW+1)'(term) <<< 16);
          den_s <= den_c;
          state <= S_DVS;
        end
        S_DVS: begin
          num_mag <= num_s[DW] ? DW'(-num_s) : DW'(num_s);
          den_mag <= den_s[16] ? 16'(-den_s) : 16'(den_s);
          q_neg   <= num_s[DW] ^ den_s[16];
          rem     <= 17'd0;
          bitc    <= 6'd0;
          if (den_s == 17'sd0) begin
            if (num_s > 0) begin
              res[d] <= 32'sh7FFF_FFFF;
            end else if (num_s < 0) begin
              res[d] <= 32'sh8000_0000;
            end else begin
              res[d] <= 32'sd0;
            end
            state <= S_SAT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= ge ? (rs - {1'b0, den_mag}) : rs;
          num_mag <= {num_mag[DW-2:0], ge};
          bitc    <= bitc + 6'd1;
          if (bitc == 6'(DW - 1)) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          if (den_s != 17'sd0) begin
            if (q_neg) begin
              res[d] <= (num_mag > DW'(32'h8000_0000)) ? 32'sh8000_0000
                                                       : 32'(-num_mag);
            end else begin
              res[d] <= (num_mag > DW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                       : 32'(num_mag);
            end
          end
          if (d == 3'd7) begin
            cx    <= sqv_pkg::Q30_INV_GAIN;
            cy    <= 34'sd0;
            cneg  <= ^phase[31:30];
            cz    <= 34'(signed'({phase[31] ^ (^phase[31:30]), phase[30:0]}));
            it    <= 5'd0;
            state <= S_CORD;
          end else begin
            d     <= d + 3'd1;
            state <= S_NUM;
          end
        end
        S_CORD: begin
          if (!cz[33]) begin
            cx <= cx - sh_x;
            cy <= cy + sh_y;
            cz <= cz - 34'(sqv_pkg::atan_turn(it));
          end else begin
            cx <= cx + sh_x;
            cy <= cy - sh_y;
            cz <= cz + 34'(sqv_pkg::atan_turn(it));
          end
          it <= it + 5'd1;
          if (it == 5'(sqv_pkg::CORDIC_STEPS - 1)) begin
            p     <= 3'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod[p] <= ma * mb;
          p       <= p + 3'd1;
          if (p == 3'd7) begin
            k     <= 2'd0;
            state <= S_ROT;
          end
        end
        S_ROT: begin
          rx    <= 34'(sum_x >>> 30);
          ry    <= 34'(sum_y >>> 30);
          state <= S_OUT;
        end
        S_OUT: begin
          if (slot_free) begin
            m_tdata  <= {16'(vn), job_r.tint, tex_v, u_sel, pos_y, pos_x};
            m_tuser  <= {1'b0, (k == 2'd0) && job_r.flush};
            m_tlast  <= (k == 2'd3);
            k        <= k + 2'd1;
            state    <= (k == 2'd3) ? S_IDLE : S_ROT;
          end
        end
        S_ERR: begin
          if (slot_free) begin
            m_tdata  <= '0;
            m_tuser  <= 2'b10;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tlast)
    else $error("error beat without last");
  a_flush_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[175:160] == 16'd0))
    else $error("flush beat with nonzero vertex number");
  a_div_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (den_mag != 16'd0))
    else $error("divider running on zero divisor");

endmodule
